FILE: rtl/lms_pkg.sv
// Shared constants, types and command struct of the LMS adaptive filter.
package lms_pkg;

	localparam int TAPS   = 16;
	localparam int IDX_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int CNT_W  = $clog2(TAPS + 1);

	localparam int SMP_W  = 16;                  // Q1.15 sample / desired / output
	localparam int WGT_W  = 24;                  // Q4.20 weight
	localparam int STEP_W = 16;                  // Q0.16 step size
	localparam int PROD_W = WGT_W + SMP_W;       // Q5.35 product
	localparam int ACC_W  = PROD_W + $clog2(TAPS + 1);
	localparam int ERR_W  = SMP_W + 1;           // Q2.15 error
	localparam int MUE_W  = STEP_W + 1 + ERR_W;  // step * error
	localparam int UPD_W  = MUE_W + SMP_W;       // step * error * sample
	localparam int WSUM_W = WGT_W + 1;

	localparam int Y_SHIFT = 20;
	localparam int W_SHIFT = 26;

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(328);

	localparam logic signed [ACC_W-1:0]  ACC_Y_MAX  = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0]  ACC_Y_MIN  = ACC_W'(-32768);
	localparam logic signed [WSUM_W-1:0] WSUM_W_MAX = WSUM_W'(8388607);
	localparam logic signed [WSUM_W-1:0] WSUM_W_MIN = WSUM_W'(-8388608);

	typedef logic signed [SMP_W-1:0] smp_t;
	typedef logic signed [WGT_W-1:0] wgt_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_ROUND,
		ST_ERR,
		ST_UPD,
		ST_DONE
	} lms_state_t;

	typedef struct packed {
		logic             load;      // store sample, clear accumulator
		logic             mul;       // output pass: multiply tap
		logic             acc;       // output pass: accumulate product
		logic             round;     // round and saturate output
		logic             err;       // form step * error
		logic             upd_mul;   // update pass: multiply tap
		logic             upd_wr;    // update pass: write weight
		logic             emit;      // load output register, advance position
		logic [IDX_W-1:0] tap;
	} lms_cmd_t;

endpackage

FILE: rtl/lms_if.sv
// Valid/ready channel interfaces for samples in and filter results out.
interface lms_in_if;
	logic               valid;
	logic               ready;
	lms_pkg::smp_t      sample_in;
	lms_pkg::smp_t      desired_in;

	modport source (output valid, output sample_in, output desired_in, input ready);
	modport sink   (input valid, input sample_in, input desired_in, output ready);
endinterface

interface lms_out_if;
	logic               valid;
	logic               ready;
	lms_pkg::smp_t      filter_out;

	modport source (output valid, output filter_out, input ready);
	modport sink   (input valid, input filter_out, output ready);
endinterface

FILE: rtl/lms_ctrl.sv
// Sequencer for the output pass, rounding, error and weight update pass.
module lms_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_ready,
	output logic                out_valid,
	output lms_pkg::lms_cmd_t   cmd
);

	lms_pkg::lms_state_t             state_q, state_d;
	logic [lms_pkg::CNT_W-1:0]       cnt_q, cnt_d;
	logic                            out_valid_q;
	logic                            cnt_last;
	logic                            can_emit;

	assign cnt_last = (cnt_q == lms_pkg::CNT_W'(lms_pkg::TAPS));
	assign can_emit = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			lms_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = lms_pkg::ST_MAC;
					cnt_d   = '0;
				end
			end
			lms_pkg::ST_MAC: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_last) begin
					state_d = lms_pkg::ST_ROUND;
					cnt_d   = '0;
				end
			end
			lms_pkg::ST_ROUND: state_d = lms_pkg::ST_ERR;
			lms_pkg::ST_ERR:   state_d = lms_pkg::ST_UPD;
			lms_pkg::ST_UPD: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_last) begin
					state_d = lms_pkg::ST_DONE;
					cnt_d   = '0;
				end
			end
			lms_pkg::ST_DONE: begin
				if (can_emit) state_d = lms_pkg::ST_IDLE;
			end
			default: state_d = lms_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.tap  = cnt_q[lms_pkg::IDX_W-1:0];
		in_ready = 1'b0;
		unique case (state_q)
			lms_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			lms_pkg::ST_MAC: begin
				cmd.mul = !cnt_last;
				cmd.acc = (cnt_q != '0);
			end
			lms_pkg::ST_ROUND: cmd.round = 1'b1;
			lms_pkg::ST_ERR:   cmd.err   = 1'b1;
			lms_pkg::ST_UPD: begin
				cmd.upd_mul = !cnt_last;
				cmd.upd_wr  = (cnt_q != '0);
			end
			lms_pkg::ST_DONE: cmd.emit = can_emit;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lms_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/lms_dp.sv
// Datapath: sample history, weights, multipliers, accumulator, output register.
module lms_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lms_pkg::lms_cmd_t             cmd,
	input  lms_pkg::smp_t                 sample_in,
	input  lms_pkg::smp_t                 desired_in,
	input  logic                          cfg_wr_en,
	input  logic [lms_pkg::STEP_W-1:0]    cfg_wr_data,
	output lms_pkg::smp_t                 filter_out
);

	logic [lms_pkg::STEP_W-1:0]           step_q;
	lms_pkg::smp_t                        hist_q [lms_pkg::TAPS];
	lms_pkg::wgt_t                        wgt_q  [lms_pkg::TAPS];
	logic [lms_pkg::IDX_W-1:0]            pos_q;
	lms_pkg::smp_t                        desired_q;
	lms_pkg::smp_t                        y_q;
	lms_pkg::smp_t                        out_q;
	logic signed [lms_pkg::ACC_W-1:0]     acc_q;
	logic signed [lms_pkg::MUE_W-1:0]     mue_q;
	logic signed [lms_pkg::PROD_W-1:0]    prod_s1;
	logic signed [lms_pkg::UPD_W-1:0]     uprod_s1;
	logic [lms_pkg::IDX_W-1:0]            widx_s1;

	logic [lms_pkg::IDX_W-1:0]            hidx;
	logic [lms_pkg::IDX_W-1:0]            widx;
	lms_pkg::smp_t                        hist_rd;
	lms_pkg::wgt_t                        wgt_rd;
	logic signed [lms_pkg::ACC_W-1:0]     acc_rnd;
	logic signed [lms_pkg::ACC_W-1:0]     acc_sh;
	lms_pkg::smp_t                        y_sat;
	logic signed [lms_pkg::ERR_W-1:0]     err;
	logic signed [lms_pkg::STEP_W:0]      step_sx;
	logic signed [lms_pkg::UPD_W-1:0]     upd_rnd;
	logic signed [lms_pkg::WSUM_W-1:0]    inc;
	logic signed [lms_pkg::WSUM_W-1:0]    wsum;
	lms_pkg::wgt_t                        wnew;

	// history slot of the sample that arrived tap steps ago
	assign hidx = (pos_q >= cmd.tap)
		? pos_q - cmd.tap
		: pos_q + lms_pkg::IDX_W'(lms_pkg::TAPS) - cmd.tap;
	// one weight read port: update pass reads the slot being written back
	assign widx    = cmd.upd_wr ? widx_s1 : cmd.tap;
	assign hist_rd = hist_q[hidx];
	assign wgt_rd  = wgt_q[widx];

	// output: add half LSB, floor, saturate
	assign acc_rnd = acc_q + (lms_pkg::ACC_W'(1) <<< (lms_pkg::Y_SHIFT - 1));
	assign acc_sh  = acc_rnd >>> lms_pkg::Y_SHIFT;
	always_comb begin
		priority if (acc_sh > lms_pkg::ACC_Y_MAX)
			y_sat = lms_pkg::SMP_W'(lms_pkg::ACC_Y_MAX);
		else if (acc_sh < lms_pkg::ACC_Y_MIN)
			y_sat = lms_pkg::SMP_W'(lms_pkg::ACC_Y_MIN);
		else
			y_sat = acc_sh[lms_pkg::SMP_W-1:0];
	end

	assign err     = lms_pkg::ERR_W'(desired_q) - lms_pkg::ERR_W'(y_q);
	assign step_sx = signed'({1'b0, step_q});

	// weight increment rounded to Q4.20, then saturating add
	assign upd_rnd = uprod_s1 + (lms_pkg::UPD_W'(1) <<< (lms_pkg::W_SHIFT - 1));
	assign inc     = lms_pkg::WSUM_W'(upd_rnd >>> lms_pkg::W_SHIFT);
	assign wsum    = lms_pkg::WSUM_W'(wgt_rd) + inc;
	always_comb begin
		priority if (wsum > lms_pkg::WSUM_W_MAX)
			wnew = lms_pkg::WGT_W'(lms_pkg::WSUM_W_MAX);
		else if (wsum < lms_pkg::WSUM_W_MIN)
			wnew = lms_pkg::WGT_W'(lms_pkg::WSUM_W_MIN);
		else
			wnew = wsum[lms_pkg::WGT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= lms_pkg::STEP_RESET;
			pos_q  <= '0;
			for (int i = 0; i < lms_pkg::TAPS; i++) begin
				hist_q[i] <= '0;
				wgt_q[i]  <= '0;
			end
		end else begin
			if (cfg_wr_en)
				step_q <= cfg_wr_data;
			if (cmd.load)
				hist_q[pos_q] <= sample_in;
			if (cmd.upd_wr)
				wgt_q[widx_s1] <= wnew;
			if (cmd.emit)
				pos_q <= (pos_q == lms_pkg::IDX_W'(lms_pkg::TAPS - 1)) ? '0 : pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			desired_q <= desired_in;
			acc_q     <= '0;
		end else if (cmd.acc) begin
			acc_q <= acc_q + lms_pkg::ACC_W'(prod_s1);
		end
		if (cmd.mul)
			prod_s1 <= wgt_rd * hist_rd;
		if (cmd.round)
			y_q <= y_sat;
		if (cmd.err)
			mue_q <= step_sx * err;
		if (cmd.upd_mul) begin
			uprod_s1 <= mue_q * hist_rd;
			widx_s1  <= cmd.tap;
		end
		if (cmd.emit)
			out_q <= y_q;
	end

	assign filter_out = out_q;

endmodule

FILE: rtl/lms_adaptive_filter.sv
// LMS adaptive FIR filter, 16 taps, top level.
// Use: present sample_in and desired_in (both Q1.15) on the samples channel;
// one filter_out (Q1.15, rounded and saturated) comes back on the results
// channel for every transfer, in order. filter_out uses the weights as they
// stood before this sample; the weights are then adapted by step_size (Q0.16)
// times the error times each history sample.
// step_size is written with cfg_wr_en/cfg_wr_data, by the user only while no
// item is in flight; the block itself does not enforce this.
// Timing: a 24x16 multiplier makes one pass over the taps for the output sum,
// and a 34x16 one a second pass over the taps for the weight update.
// A new sample is taken only once both passes of the last one are done and
// its result has been moved into the output register.
// The output register lets the block take the next sample while a result
// still waits; if the receiver stalls, the finished next result is held in
// the datapath and the block does not take a further sample until it drains.
// Reset clears history, weights and the write position, sets step_size to 328
// and drops results.valid.
module lms_adaptive_filter (
	input  logic                        clk,
	input  logic                        arst_n,
	lms_in_if.sink                      samples,
	lms_out_if.source                   results,
	input  logic                        cfg_wr_en,
	input  logic [lms_pkg::STEP_W-1:0]  cfg_wr_data
);

	lms_pkg::lms_cmd_t cmd;

	lms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_ready (results.ready),
		.out_valid (results.valid),
		.cmd       (cmd)
	);

	lms_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sample_in   (samples.sample_in),
		.desired_in  (samples.desired_in),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.filter_out  (results.filter_out)
	);

	// busy right after a sample transfer
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> !samples.ready)
		else $error("sample taken while previous item still in work");

	// results only appear from the emit step
	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(results.valid) |-> $past(cmd.emit))
		else $error("result valid without emit");

	// a result is never emitted while the input side is open
	a_emit_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !samples.ready)
		else $error("emit while idle");

	// weight writes never overlap the output pass
	a_passes_apart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd_wr |-> !(cmd.mul || cmd.acc || cmd.load))
		else $error("update pass overlaps output pass");

endmodule
